### sv/psm_pkg.sv
// Shared codes, field widths and control structs for the payload signature matcher.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package psm_pkg;

    localparam int DATA_W      = 8;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 3;
    localparam int OUT_TDATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

    // window control: shift in a payload byte, end of payload run
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    // signature collection control: push a signature byte, end of run
    typedef struct packed {
        logic push;
        logic clear;
    } t_col_ctl;

    // table update: store the collected signature, or drop an entry
    typedef struct packed {
        logic add;
        logic del;
    } t_tbl_op;

endpackage

`default_nettype wire

### sv/psm_window.sv
// Payload sliding window and fill count, with the next-window view for comparison.
// Depends on psm_pkg.
`default_nettype none

module psm_window #(
    parameter int MAX_SIG_LEN = 16,
    parameter int LEN_W       = 5
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  psm_pkg::t_win_ctl               i_ctl,
    input  wire  [psm_pkg::DATA_W-1:0]      i_byte,
    output logic [MAX_SIG_LEN*psm_pkg::DATA_W-1:0] o_win_next,
    output logic [LEN_W-1:0]                o_fill_next
);

    localparam int DW = psm_pkg::DATA_W;

    logic [MAX_SIG_LEN*DW-1:0] r_win;
    logic [LEN_W-1:0]          r_fill;

    // oldest byte at position 0, newest at MAX_SIG_LEN-1
    always_comb begin
        for (int j = 0; j < MAX_SIG_LEN - 1; j++) begin
            o_win_next[j*DW +: DW] = r_win[(j+1)*DW +: DW];
        end
        o_win_next[(MAX_SIG_LEN-1)*DW +: DW] = i_byte;
    end

    assign o_fill_next = (r_fill == LEN_W'(MAX_SIG_LEN)) ? r_fill : r_fill + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_win  <= '0;
        end else if (i_ctl.shift) begin
            r_win  <= o_win_next;
            r_fill <= i_ctl.clear ? '0 : o_fill_next;
        end
    end

endmodule

`default_nettype wire

### sv/psm_collect.sv
// Collection buffer for a signature being added or removed, kept right-aligned.
// Depends on psm_pkg.
`default_nettype none

module psm_collect #(
    parameter int MAX_SIG_LEN = 16,
    parameter int LEN_W       = 5
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  psm_pkg::t_col_ctl               i_ctl,
    input  wire  [psm_pkg::DATA_W-1:0]      i_byte,
    output logic [MAX_SIG_LEN*psm_pkg::DATA_W-1:0] o_pend_next,
    output logic [LEN_W-1:0]                o_len_next,
    output logic                            o_ovf_next,
    output logic [psm_pkg::DATA_W-1:0]      o_first_next
);

    localparam int DW = psm_pkg::DATA_W;

    logic [MAX_SIG_LEN*DW-1:0] r_pend;
    logic [LEN_W-1:0]          r_len;
    logic                      r_ovf;
    logic [DW-1:0]             r_first;
    logic                      w_room;

    assign w_room = (r_len != LEN_W'(MAX_SIG_LEN));

    // bytes enter at the top, so the first byte ends up at MAX_SIG_LEN - length
    always_comb begin
        if (w_room) begin
            for (int j = 0; j < MAX_SIG_LEN - 1; j++) begin
                o_pend_next[j*DW +: DW] = r_pend[(j+1)*DW +: DW];
            end
            o_pend_next[(MAX_SIG_LEN-1)*DW +: DW] = i_byte;
        end else begin
            o_pend_next = r_pend;
        end
    end

    assign o_len_next   = w_room ? r_len + LEN_W'(1) : r_len;
    assign o_ovf_next   = r_ovf | ~w_room;
    assign o_first_next = (r_len == '0) ? i_byte : r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctl.push) begin
            r_len <= i_ctl.clear ? '0 : o_len_next;
            r_ovf <= i_ctl.clear ? 1'b0 : o_ovf_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_pend  <= o_pend_next;
            r_first <= o_first_next;
        end
    end

endmodule

`default_nettype wire

### sv/psm_sig_table.sv
// Signature table: right-aligned entries, parallel window and removal comparators.
// Depends on psm_pkg.
`default_nettype none

module psm_sig_table #(
    parameter int NUM_SIGS    = 8,
    parameter int MAX_SIG_LEN = 16,
    parameter int LEN_W       = 5,
    parameter int SLOT_W      = 3
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire  [MAX_SIG_LEN*psm_pkg::DATA_W-1:0] i_win,
    input  wire  [LEN_W-1:0]                       i_fill,
    input  wire  [MAX_SIG_LEN*psm_pkg::DATA_W-1:0] i_pend,
    input  wire  [LEN_W-1:0]                       i_plen,
    input  psm_pkg::t_tbl_op                       i_op,
    input  wire  [SLOT_W-1:0]                      i_slot,
    output logic                                   o_hit,
    output logic [NUM_SIGS-1:0]                    o_eq,
    output logic [NUM_SIGS-1:0]                    o_free
);

    localparam int DW = psm_pkg::DATA_W;

    logic [MAX_SIG_LEN*DW-1:0] r_bytes [NUM_SIGS];
    logic [LEN_W-1:0]          r_len   [NUM_SIGS];
    logic [NUM_SIGS-1:0]       r_valid;
    logic [NUM_SIGS-1:0]       w_hit_vec;

    always_comb begin
        logic win_ok;
        logic pend_ok;
        for (int s = 0; s < NUM_SIGS; s++) begin
            win_ok  = 1'b1;
            pend_ok = 1'b1;
            for (int j = 0; j < MAX_SIG_LEN; j++) begin
                // byte j belongs to the entry when j >= MAX_SIG_LEN - length
                if (r_len[s] > LEN_W'(MAX_SIG_LEN - 1 - j) &&
                    r_bytes[s][j*DW +: DW] != i_win[j*DW +: DW]) begin
                    win_ok = 1'b0;
                end
                if (i_plen > LEN_W'(MAX_SIG_LEN - 1 - j) &&
                    r_bytes[s][j*DW +: DW] != i_pend[j*DW +: DW]) begin
                    pend_ok = 1'b0;
                end
            end
            w_hit_vec[s] = r_valid[s] && (r_len[s] != '0) && (r_len[s] <= i_fill) && win_ok;
            o_eq[s]      = r_valid[s] && (r_len[s] == i_plen) && pend_ok;
        end
    end

    assign o_hit  = |w_hit_vec;
    assign o_free = ~r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int s = 0; s < NUM_SIGS; s++) begin
                r_len[s] <= '0;
            end
        end else if (i_op.add) begin
            r_valid[i_slot] <= 1'b1;
            r_len[i_slot]   <= i_plen;
        end else if (i_op.del) begin
            r_valid[i_slot] <= 1'b0;
            r_len[i_slot]   <= '0;
        end
    end

    // entry bytes hold no reset; only the length-masked part is ever compared
    always_ff @(posedge i_clk) begin
        if (i_op.add) begin
            r_bytes[i_slot] <= i_pend;
        end
    end

endmodule

`default_nettype wire

### sv/payload_signature_matcher.sv
// A request is held in the input register, and its result in the result register behind o_m_tvalid.
// Throughput: one request per cycle while no result is stalled; the table, window and collector
// all update at the same edge that loads the result register from the input register.
// Back-pressure on the master side stalls the input register only for requests that give
// a result. Reset (i_rst_n low, synchronous) empties the table and clears both runs.
// Depends on psm_pkg, psm_window, psm_collect and psm_sig_table.
`default_nettype none

module payload_signature_matcher #(
    parameter int NUM_SIGS    = 8,
    parameter int MAX_SIG_LEN = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // slave side: one byte per request
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire  [1:0] i_s_tuser,   // [1:0] mode
    input  wire        i_s_tlast,   // last byte of payload or signature run
    // master side: one result per run
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata    // [0] matched, [2:1] status, [5:3] slot, [7:6] zero
);

    localparam int DW         = psm_pkg::DATA_W;
    localparam int LEN_W      = $clog2(MAX_SIG_LEN + 1);
    localparam int SLOT_W     = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
    localparam int SLOT_OUT_W = psm_pkg::SLOT_OUT_W;
    localparam int BYTE_VALS  = 1 << DW;

    // input register
    logic                        r_in_vld;
    logic [psm_pkg::MODE_W-1:0]  r_in_mode;
    logic [DW-1:0]               r_in_byte;
    logic                        r_in_last;

    // result register and hit latch
    logic                        r_out_vld;
    logic [7:0]                  r_out_data;
    logic                        r_hit;

    logic                        w_out_free;
    logic                        w_gives_result;
    logic                        w_adv;
    logic                        w_is_pay;
    logic                        w_is_sig;

    psm_pkg::t_win_ctl           w_win_ctl;
    psm_pkg::t_col_ctl           w_col_ctl;
    psm_pkg::t_tbl_op            w_tbl_op;

    logic [MAX_SIG_LEN*DW-1:0]   w_win_next;
    logic [LEN_W-1:0]            w_fill_next;
    logic [MAX_SIG_LEN*DW-1:0]   w_pend_next;
    logic [LEN_W-1:0]            w_len_next;
    logic                        w_ovf_next;
    logic [DW-1:0]               w_first_next;

    logic                        w_hit_now;
    logic [NUM_SIGS-1:0]         w_eq;
    logic [NUM_SIGS-1:0]         w_free;
    logic [NUM_SIGS-1:0]         w_cand;
    logic [SLOT_W-1:0]           w_start;
    logic [SLOT_W-1:0]           w_idx;
    logic                        w_found;
    logic [psm_pkg::STATUS_W-1:0] w_status;
    logic [SLOT_OUT_W-1:0]       w_slot_out;
    logic                        w_matched;

    // start slot = first byte mod NUM_SIGS, as a constant table
    logic [SLOT_W-1:0]           w_start_tab [BYTE_VALS];

    for (genvar v = 0; v < BYTE_VALS; v++) begin : g_start_tab
        assign w_start_tab[v] = SLOT_W'(v % NUM_SIGS);
    end

    // ---------------------------------------------------------------------
    // Handshake. The processing stage advances unless it owes a result and
    // the result register is still full.
    // ---------------------------------------------------------------------
    assign w_out_free     = !r_out_vld || i_m_tready;
    assign w_gives_result = r_in_last && (r_in_mode != psm_pkg::MODE_RSVD);
    assign w_adv          = r_in_vld && (!w_gives_result || w_out_free);
    assign o_s_tready     = !r_in_vld || w_adv;

    assign w_is_pay = (r_in_mode == psm_pkg::MODE_PAYLOAD);
    assign w_is_sig = (r_in_mode == psm_pkg::MODE_ADD) || (r_in_mode == psm_pkg::MODE_DEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode <= i_s_tuser;
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath units
    // ---------------------------------------------------------------------
    assign w_win_ctl.shift = w_adv && w_is_pay;
    assign w_win_ctl.clear = r_in_last;
    assign w_col_ctl.push  = w_adv && w_is_sig;
    assign w_col_ctl.clear = r_in_last;

    psm_window #(
        .MAX_SIG_LEN (MAX_SIG_LEN),
        .LEN_W       (LEN_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_win_ctl),
        .i_byte      (r_in_byte),
        .o_win_next  (w_win_next),
        .o_fill_next (w_fill_next)
    );

    psm_collect #(
        .MAX_SIG_LEN  (MAX_SIG_LEN),
        .LEN_W        (LEN_W)
    ) u_collect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_col_ctl),
        .i_byte       (r_in_byte),
        .o_pend_next  (w_pend_next),
        .o_len_next   (w_len_next),
        .o_ovf_next   (w_ovf_next),
        .o_first_next (w_first_next)
    );

    psm_sig_table #(
        .NUM_SIGS    (NUM_SIGS),
        .MAX_SIG_LEN (MAX_SIG_LEN),
        .LEN_W       (LEN_W),
        .SLOT_W      (SLOT_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (w_win_next),
        .i_fill      (w_fill_next),
        .i_pend      (w_pend_next),
        .i_plen      (w_len_next),
        .i_op        (w_tbl_op),
        .i_slot      (w_idx),
        .o_hit       (w_hit_now),
        .o_eq        (w_eq),
        .o_free      (w_free)
    );

    // ---------------------------------------------------------------------
    // Slot search: lowest candidate at or above the start slot, no wrap.
    // Add looks for a free slot, remove for an equal valid entry.
    // ---------------------------------------------------------------------
    assign w_start = w_start_tab[w_first_next];

    always_comb begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            w_cand[s] = ((r_in_mode == psm_pkg::MODE_ADD) ? w_free[s] : w_eq[s]) &&
                        (SLOT_W'(s) >= w_start);
        end
        w_idx = '0;
        for (int s = NUM_SIGS - 1; s >= 0; s--) begin
            if (w_cand[s]) begin
                w_idx = SLOT_W'(s);
            end
        end
    end

    assign w_found = |w_cand;

    // table changes only on the last byte of a signature run that fits
    assign w_tbl_op.add = w_col_ctl.push && r_in_last && !w_ovf_next && w_found &&
                          (r_in_mode == psm_pkg::MODE_ADD);
    assign w_tbl_op.del = w_col_ctl.push && r_in_last && !w_ovf_next && w_found &&
                          (r_in_mode == psm_pkg::MODE_DEL);

    // ---------------------------------------------------------------------
    // Result fields
    // ---------------------------------------------------------------------
    always_comb begin
        w_status   = psm_pkg::ST_OK;
        w_slot_out = '0;
        w_matched  = 1'b0;
        if (w_is_pay) begin
            w_matched = r_hit || w_hit_now;
        end else if (w_ovf_next) begin
            w_status = psm_pkg::ST_TOO_LONG;
        end else if (!w_found) begin
            w_status = (r_in_mode == psm_pkg::MODE_ADD) ? psm_pkg::ST_FULL
                                                        : psm_pkg::ST_NOT_FOUND;
        end else begin
            w_slot_out = SLOT_OUT_W'(w_idx);
        end
    end

    // hit latch spans one payload run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (w_win_ctl.shift) begin
            r_hit <= r_in_last ? 1'b0 : (r_hit || w_hit_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_gives_result) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_gives_result) begin
            r_out_data <= {2'b00, w_slot_out, w_status, w_matched};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

### sv/psm_checker.sv
// Port-level checks for payload_signature_matcher, bound onto the top level.
// Depends on psm_pkg and payload_signature_matcher.
`default_nettype none

module psm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_s_tvalid,
    input wire       o_s_tready,
    input wire [7:0] i_s_tdata,
    input wire [1:0] i_s_tuser,
    input wire       i_s_tlast,
    input wire       o_m_tvalid,
    input wire       i_m_tready,
    input wire [7:0] o_m_tdata
);

    // a waiting request is held unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=>
            i_s_tvalid && $stable({i_s_tuser, i_s_tdata, i_s_tlast}))
        else $error("request changed while stalled");

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // padding bits stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:6] == 2'b00)
        else $error("result padding not zero");

    // a payload hit carries ok status and slot zero
    a_match_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |->
            o_m_tdata[2:1] == psm_pkg::ST_OK && o_m_tdata[5:3] == 3'd0)
        else $error("payload hit with status or slot set");

    // a failed table operation reports no slot
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:1] != psm_pkg::ST_OK |-> o_m_tdata[5:3] == 3'd0)
        else $error("slot reported on failed table operation");

endmodule

bind payload_signature_matcher psm_checker u_psm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
